// ----- sv/gtc_pkg.sv -----
package gtc_pkg;

	// Hash multipliers for the home slot.
	localparam logic [31:0] HASH_CODE_MUL   = 32'd31;
	localparam logic [31:0] HASH_BUCKET_MUL = 32'd2654435761;

	// Result status codes.
	localparam logic [1:0] RES_HIT  = 2'd0;
	localparam logic [1:0] RES_MISS = 2'd1;
	localparam logic [1:0] RES_FULL = 2'd2;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_MATCH,
		ST_PICK,
		ST_MOD,
		ST_ISSUE,
		ST_PROBE,
		ST_DONE
	} gtc_state_t;

	// One slot of the tag store.
	typedef struct packed {
		logic        valid;
		logic [7:0]  code;
		logic [31:0] size;
	} gtc_entry_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic clr_we;
		logic accept;
		logic match;
		logic pick;
		logic mod_step;
		logic issue;
		logic probe_adv;
		logic claim;
		logic res_load;
		logic res_full;
		logic out_load;
	} gtc_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic clr_last;
		logic mod_last;
		logic hit;
		logic empty;
		logic probe_last;
	} gtc_sts_t;

	function automatic logic is_nan(input logic [31:0] b);
		return (b[30:23] == 8'hFF) && (b[22:0] != 23'd0);
	endfunction

	// Float equality on bit patterns: both zeros are equal, NaN equals nothing.
	function automatic logic size_equal(input logic [31:0] a, input logic [31:0] b);
		logic r;
		if (is_nan(a) || is_nan(b)) begin
			r = 1'b0;
		end else if (((a | b) & 32'h7FFF_FFFF) == 32'd0) begin
			r = 1'b1;
		end else begin
			r = (a == b);
		end
		return r;
	endfunction

endpackage

// ----- sv/gtc_ctrl.sv -----
module gtc_ctrl
	import gtc_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_stall,
	output logic     out_valid,
	input  logic     out_stall,
	input  gtc_sts_t sts,
	output gtc_cmd_t cmd
);

	gtc_state_t state_q;
	gtc_state_t state_d;
	logic       out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;

	always_comb begin
		cmd      = '0;
		state_d  = state_q;
		in_stall = 1'b1;
		case (state_q)
			ST_CLEAR: begin
				cmd.clr_we = 1'b1;
				if (sts.clr_last) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					cmd.accept = 1'b1;
					state_d    = ST_MATCH;
				end
			end
			ST_MATCH: begin
				cmd.match = 1'b1;
				state_d   = ST_PICK;
			end
			ST_PICK: begin
				cmd.pick = 1'b1;
				state_d  = ST_MOD;
			end
			ST_MOD: begin
				cmd.mod_step = 1'b1;
				if (sts.mod_last) begin
					state_d = ST_ISSUE;
				end
			end
			ST_ISSUE: begin
				cmd.issue = 1'b1;
				state_d   = ST_PROBE;
			end
			ST_PROBE: begin
				if (sts.hit) begin
					cmd.res_load = 1'b1;
					state_d      = ST_DONE;
				end else if (sts.empty) begin
					cmd.claim    = 1'b1;
					cmd.res_load = 1'b1;
					state_d      = ST_DONE;
				end else if (sts.probe_last) begin
					cmd.res_load = 1'b1;
					cmd.res_full = 1'b1;
					state_d      = ST_DONE;
				end else begin
					cmd.probe_adv = 1'b1;
				end
			end
			ST_DONE: begin
				if (!out_valid_q || !out_stall) begin
					cmd.out_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

// ----- sv/gtc_dp.sv -----
module gtc_dp
	import gtc_pkg::*;
#(
	parameter int SLOT_COUNT   = 512,
	parameter int SIZE_BUCKETS = 8,
	parameter int PROBE_LIMIT  = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	input  gtc_cmd_t    cmd,
	output gtc_sts_t    sts,
	input  logic [7:0]  char_code,
	input  logic [31:0] size_bits,
	output logic [1:0]  status,
	output logic [8:0]  slot_index,
	output logic [2:0]  size_bucket
);

	localparam int  SLOT_W = $clog2(SLOT_COUNT);
	localparam int  BKT_W  = (SIZE_BUCKETS > 1) ? $clog2(SIZE_BUCKETS) : 1;
	localparam int  CNT_W  = $clog2(SIZE_BUCKETS + 1);
	localparam int  PRB_W  = (PROBE_LIMIT > 1) ? $clog2(PROBE_LIMIT) : 1;
	localparam bit  POW2   = ((SLOT_COUNT & (SLOT_COUNT - 1)) == 0);

	// Request registers.
	logic [7:0]  code_q;
	logic [31:0] size_q;

	// Size table.
	logic [31:0]             size_tab_q [SIZE_BUCKETS];
	logic [CNT_W-1:0]        size_cnt_q;
	logic [SIZE_BUCKETS-1:0] match_q;
	logic [BKT_W-1:0]        bucket_d;
	logic [BKT_W-1:0]        bucket_q;
	logic                    found;
	logic [BKT_W-1:0]        found_idx;
	logic                    learn;
	logic [31:0]             key_d;
	logic [31:0]             key_q;
	logic [SLOT_W-1:0]       home_d;
	logic [SLOT_W-1:0]       home_q;
	logic [SLOT_W-1:0]       home_w;

	// Slot store and probe.
	gtc_entry_t        mem [SLOT_COUNT];
	gtc_entry_t        rd_q;
	gtc_entry_t        wr_data;
	logic              wr_en;
	logic [SLOT_W-1:0] wr_addr;
	logic [SLOT_W-1:0] rd_addr;
	logic [SLOT_W-1:0] clr_addr_q;
	logic [SLOT_W-1:0] slot_q;
	logic [SLOT_W-1:0] slot_next;
	logic [PRB_W-1:0]  probe_q;

	// Result.
	logic [1:0]        res_status_q;
	logic [SLOT_W-1:0] res_slot_q;
	logic [31:0]       slot_ext;
	logic [15:0]       bkt_ext;

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			code_q <= char_code;
			size_q <= size_bits;
		end
	end

	// Bucket lookup: compare all learned sizes, then take the lowest match.
	always_ff @(posedge clk) begin
		for (int i = 0; i < SIZE_BUCKETS; i++) begin
			if (cmd.match) begin
				match_q[i] <= (CNT_W'(i) < size_cnt_q) && size_equal(size_tab_q[i], size_q);
			end
		end
	end

	always_comb begin
		found     = 1'b0;
		found_idx = '0;
		for (int i = SIZE_BUCKETS - 1; i >= 0; i--) begin
			if (match_q[i]) begin
				found     = 1'b1;
				found_idx = BKT_W'(i);
			end
		end
		learn = !found && (size_cnt_q < CNT_W'(SIZE_BUCKETS));
		if (found) begin
			bucket_d = found_idx;
		end else if (learn) begin
			bucket_d = BKT_W'(size_cnt_q);
		end else begin
			bucket_d = '0;
		end
		key_d = 32'(32'(code_q) * HASH_CODE_MUL + 32'(bucket_d) * HASH_BUCKET_MUL);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_cnt_q <= '0;
		end else if (cmd.pick && learn) begin
			size_cnt_q <= size_cnt_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.pick) begin
			bucket_q <= bucket_d;
			key_q    <= key_d;
			if (learn) begin
				size_tab_q[BKT_W'(size_cnt_q)] <= size_q;
			end
		end
	end

	// Home slot: a mask for a power-of-two store. Otherwise the remainder is
	// built from constant per-code and per-bucket remainders, corrected once
	// when the 32-bit key sum wrapped.
	generate
		if (POW2) begin : g_mask
			assign home_d = key_q[SLOT_W-1:0];
		end else begin : g_rem
			localparam int BKT_N = 1 << BKT_W;
			localparam logic [SLOT_W-1:0] WRAP_REM =
				SLOT_W'((64'd1 << 32) % 64'(SLOT_COUNT));
			logic [SLOT_W-1:0] code_rem [256];
			logic [SLOT_W-1:0] bkt_rem  [BKT_N];
			logic              wrap;
			logic [SLOT_W:0]   sum;
			logic [SLOT_W-1:0] part;

			for (genvar g = 0; g < 256; g++) begin : g_code
				assign code_rem[g] =
					SLOT_W'((64'(g) * 64'(HASH_CODE_MUL)) % 64'(SLOT_COUNT));
			end

			for (genvar g = 0; g < BKT_N; g++) begin : g_bkt
				assign bkt_rem[g] = SLOT_W'(((64'(g) * 64'(HASH_BUCKET_MUL))
					& 64'hFFFF_FFFF) % 64'(SLOT_COUNT));
			end

			always_comb begin
				// The sum wrapped exactly when the key fell below the code term.
				wrap = (key_q < 32'(32'(code_q) * HASH_CODE_MUL));
				sum  = {1'b0, code_rem[code_q]} + {1'b0, bkt_rem[bucket_q]};
				if (sum >= (SLOT_W + 1)'(SLOT_COUNT)) begin
					part = SLOT_W'(sum - (SLOT_W + 1)'(SLOT_COUNT));
				end else begin
					part = SLOT_W'(sum);
				end
				if (!wrap) begin
					home_d = part;
				end else if (part >= WRAP_REM) begin
					home_d = part - WRAP_REM;
				end else begin
					home_d = SLOT_W'((SLOT_W + 1)'(part) + (SLOT_W + 1)'(SLOT_COUNT)
						- (SLOT_W + 1)'(WRAP_REM));
				end
			end
		end
	endgenerate

	always_ff @(posedge clk) begin
		if (cmd.mod_step) begin
			home_q <= home_d;
		end
	end

	assign home_w       = home_q;
	assign sts.mod_last = 1'b1;

	// Slot store.
	assign slot_next = (slot_q == SLOT_W'(SLOT_COUNT - 1)) ? '0 : slot_q + 1'b1;
	assign rd_addr   = cmd.probe_adv ? slot_next : home_w;
	assign wr_en     = cmd.clr_we || cmd.claim;
	assign wr_addr   = cmd.clr_we ? clr_addr_q : slot_q;

	always_comb begin
		wr_data = '0;
		if (cmd.claim) begin
			wr_data.valid = 1'b1;
			wr_data.code  = code_q;
			wr_data.size  = size_q;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_q <= mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_addr_q <= '0;
		end else if (cmd.clr_we) begin
			clr_addr_q <= clr_addr_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.issue) begin
			slot_q  <= home_w;
			probe_q <= '0;
		end else if (cmd.probe_adv) begin
			slot_q  <= slot_next;
			probe_q <= probe_q + 1'b1;
		end
	end

	assign sts.clr_last   = (clr_addr_q == SLOT_W'(SLOT_COUNT - 1));
	assign sts.hit        = rd_q.valid && (rd_q.code == code_q) && size_equal(rd_q.size, size_q);
	assign sts.empty      = !rd_q.valid;
	assign sts.probe_last = (probe_q == PRB_W'(PROBE_LIMIT - 1));

	// Result and output registers.
	always_ff @(posedge clk) begin
		if (cmd.res_load) begin
			if (cmd.res_full) begin
				res_status_q <= RES_FULL;
				res_slot_q   <= '0;
			end else begin
				res_status_q <= cmd.claim ? RES_MISS : RES_HIT;
				res_slot_q   <= slot_q;
			end
		end
	end

	assign slot_ext = 32'(res_slot_q);
	assign bkt_ext  = 16'(bucket_q);

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			status      <= res_status_q;
			slot_index  <= slot_ext[8:0];
			size_bucket <= bkt_ext[2:0];
		end
	end

endmodule

// ----- sv/glyph_tag_cache_linear_probe.sv -----
// Sequence: after its input transfer a request passes MATCH, PICK, MOD, ISSUE, then PROBE for each slot
// probed (1 to PROBE_LIMIT slots) and DONE; the home slot takes the single MOD step whatever SLOT_COUNT is.
// Throughput: one request at a time; the next transfer is taken only after the previous leaves DONE,
// set by the single read port of the slot store, probed one slot per cycle.
// Reset: asynchronous, active low; afterwards a clearing pass empties every slot of
// the slot store, with in_stall high, and the learned size table starts empty.
module glyph_tag_cache_linear_probe
	import gtc_pkg::*;
#(
	parameter int SLOT_COUNT   = 512,
	parameter int SIZE_BUCKETS = 8,
	parameter int PROBE_LIMIT  = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  char_code,
	input  logic [31:0] size_bits,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  status,
	output logic [8:0]  slot_index,
	output logic [2:0]  size_bucket
);

	// The controller sequences each request through size lookup, hashing and
	// probing; the datapath holds the size table, the slot store and the result.
	gtc_cmd_t cmd;
	gtc_sts_t sts;

	// The controller owns the handshakes. It takes a transfer only when idle, and
	// it moves a finished result into the output register once that register is
	// free or being drained, so a result waiting downstream does not block the
	// lookup of the next request.
	gtc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	// The datapath maps the size to a bucket (learning new sizes in order), forms
	// the home slot from the hash and walks the probe run with one read per cycle,
	// claiming the first empty slot it meets.
	gtc_dp #(
		.SLOT_COUNT   (SLOT_COUNT),
		.SIZE_BUCKETS (SIZE_BUCKETS),
		.PROBE_LIMIT  (PROBE_LIMIT)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.char_code   (char_code),
		.size_bits   (size_bits),
		.status      (status),
		.slot_index  (slot_index),
		.size_bucket (size_bucket)
	);

endmodule
